### sv/bba_pkg.sv
`default_nettype none

package bba_pkg;

   // Default geometry of the bitmap
   localparam int MAX_BLOCKS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   // Field widths
   localparam int COUNT_W  = 13;
   localparam int BLOCK_W  = 12;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   // Commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [BLOCK_W-1:0]  grant;
      logic [STATUS_W-1:0] status;
   } res_type;

endpackage

`default_nettype wire

### sv/bba_map_ram.sv
`default_nettype none

module bba_map_ram #(
   parameter int WORDS = 128,
   parameter int WIDTH = 32,
   parameter int AW    = 7
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] map_mem [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/bba_ctrl.sv
`default_nettype none

module bba_ctrl #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF,
   parameter int AW         = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [bba_pkg::COUNT_W-1:0]  block_count,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         command,
   input  wire logic [bba_pkg::BLOCK_W-1:0]  block_number,
   output bba_pkg::res_type                  res,
   input  wire logic                         res_take,
   output logic                              mem_wr_en,
   output logic      [AW-1:0]                mem_wr_addr,
   output logic      [WORD_BITS-1:0]         mem_wr_data,
   output logic      [AW-1:0]                mem_rd_addr,
   input  wire logic [WORD_BITS-1:0]         mem_rd_data
);

   // WORD_BITS is a power of two
   localparam int WL        = $clog2(WORD_BITS);
   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
   localparam int CW        = (LIM_W > bba_pkg::COUNT_W) ? LIM_W : bba_pkg::COUNT_W;

   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [CW-1:0] MAX_LIM   = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] WB_C      = CW'(WORD_BITS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [AW-1:0]    dat_addr_ff, dat_addr_in;
   logic             dvalid_ff, dvalid_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [WL-1:0]    bit_ff, bit_in;
   bba_pkg::res_type res_ff, res_in;

   logic [CW-1:0]    count_ext;
   logic [CW-1:0]    limit;
   logic [CW-1:0]    blk_ext;
   logic [31:0]      blk32;
   logic [AW-1:0]    blk_word;
   logic [WL-1:0]    blk_bit;
   logic             found;
   logic [WL-1:0]    idx;
   logic [31:0]      grant32;

   // Block count saturates at the map size
   assign count_ext = CW'(block_count);
   assign limit     = (count_ext > MAX_LIM) ? MAX_LIM : count_ext;
   assign blk_ext   = CW'(block_number);
   assign blk32     = 32'(block_number);
   assign blk_word  = blk32[WL +: AW];
   assign blk_bit   = blk32[WL-1:0];

   // Lowest clear bit among those still below the limit
   always_comb begin
      found = 1'b0;
      idx   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!mem_rd_data[i] && (rem_ff > CW'(i))) begin
            found = 1'b1;
            idx   = WL'(i);
         end
      end
   end

   assign grant32 = 32'({dat_addr_ff, idx});

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      dat_addr_in = dat_addr_ff;
      dvalid_in   = dvalid_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dvalid_in = 1'b0;
               if (command == bba_pkg::CMD_ALLOC) begin
                  state_in = S_SCAN;
                  addr_in  = '0;
                  rem_in   = limit;
               end else if (blk_ext >= limit) begin
                  res_in.valid  = 1'b1;
                  res_in.grant  = '0;
                  res_in.status = bba_pkg::STAT_RANGE;
                  state_in      = S_DONE;
               end else begin
                  addr_in      = blk_word;
                  bit_in       = blk_bit;
                  res_in.grant = block_number;
                  state_in     = S_FREE;
               end
            end
         end
         S_SCAN: begin
            // one word read per cycle, data for the previous address arrives now
            dvalid_in   = 1'b1;
            dat_addr_in = addr_ff;
            if (addr_ff != LAST_WORD) begin
               addr_in = addr_ff + AW'(1);
            end
            if (dvalid_ff) begin
               if (found) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = dat_addr_ff;
                  mem_wr_data   = mem_rd_data | (WORD_BITS'(1) << idx);
                  res_in.valid  = 1'b1;
                  res_in.grant  = grant32[bba_pkg::BLOCK_W-1:0];
                  res_in.status = bba_pkg::STAT_OK;
                  state_in      = S_DONE;
               end else if (rem_ff <= WB_C) begin
                  res_in.valid  = 1'b1;
                  res_in.grant  = '0;
                  res_in.status = bba_pkg::STAT_FULL;
                  state_in      = S_DONE;
               end else begin
                  rem_in = rem_ff - WB_C;
               end
            end
         end
         S_FREE: begin
            dvalid_in = 1'b1;
            if (dvalid_ff) begin
               mem_wr_en     = 1'b1;
               mem_wr_data   = mem_rd_data & ~(WORD_BITS'(1) << bit_ff);
               res_in.valid  = 1'b1;
               res_in.status = bba_pkg::STAT_OK;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register takes the result
            if (res_take) begin
               res_in.valid = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         dvalid_ff    <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         dat_addr_ff <= dat_addr_in;
         dvalid_ff   <= dvalid_in;
         rem_ff      <= rem_in;
         bit_ff      <= bit_in;
         res_ff      <= res_in;
      end
   end

   assign res         = res_ff;
   assign mem_rd_addr = addr_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_wr_en)
      else $error("bitmap written outside a command");

   a_fail_zero_grant: assert property (@(posedge clock) disable iff (reset)
      (res_ff.valid && res_ff.status != bba_pkg::STAT_OK) |-> (res_ff.grant == '0))
      else $error("failed command carries a block number");

   a_scan_write_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_wr_en)
      |=> (res_ff.valid && res_ff.status == bba_pkg::STAT_OK))
      else $error("allocation write without ok result");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && addr_ff == LAST_WORD) |=> (state_ff == S_IDLE))
      else $error("clearing pass did not end");

   a_res_only_done: assert property (@(posedge clock) disable iff (reset)
      res_ff.valid |-> (state_ff == S_DONE))
      else $error("result pending outside done state");

endmodule

`default_nettype wire

### sv/bitmap_block_allocator.sv
`default_nettype none

// Channel  Direction  Ports                            Contents
// req      in         req_tvalid/tready/tdata/tuser    block_number (tdata), command (tuser)
// rsp      out        rsp_tvalid/tready/tdata/tuser    granted_block (tdata), status (tuser)
// csr      in         csr_wr_en/csr_wr_data            block_count
//
// Allocate reads bitmap words in turn, up to MAX_BLOCKS / WORD_BITS of them rounded
// up, through the single read port of the bitmap RAM.
// Free reads the word of the block and writes it back; a free out of range goes to done.
// After reset a clearing pass writes zeros over MAX_BLOCKS / WORD_BITS words, rounded
// up; req_tready stays low during it.
// A pending result in the output register does not block the next command
// until a second result is ready.

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [11:0] block_number, [15:12] zero
   input  wire logic [bba_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] command
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [11:0] granted_block, [15:12] zero
   output logic      [bba_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic      [bba_pkg::STATUS_W-1:0]     rsp_tuser,
   input  wire logic                             csr_wr_en,
   input  wire logic [bba_pkg::COUNT_W-1:0]      csr_wr_data
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic [bba_pkg::COUNT_W-1:0]     count_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [bba_pkg::STATUS_W-1:0]    rsp_user_ff, rsp_user_in;

   bba_pkg::res_type res;
   logic             res_take;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [AW-1:0]    mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   bba_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS),
      .AW         (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .block_count  (count_ff),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .command      (req_tuser),
      .block_number (req_tdata[bba_pkg::BLOCK_W-1:0]),
      .res          (res),
      .res_take     (res_take),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   bba_map_ram #(
      .WORDS (MAP_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // load the output register when empty or being drained
   assign res_take = res.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = bba_pkg::RSP_TDATA_W'(res.grant);
         rsp_user_in  = res.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= bba_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 1225;

   typedef struct packed {
      logic [bba_pkg::BLOCK_W-1:0]  grant;
      logic [bba_pkg::STATUS_W-1:0] status;
   } alloc_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // [11:0] block_number, [15:12] zero
   logic [bba_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] command
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [11:0] granted_block, [15:12] zero
   logic [bba_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [bba_pkg::STATUS_W-1:0]    rsp_tuser;
   logic                            csr_wr_en = 1'b0;
   logic [bba_pkg::COUNT_W-1:0]     csr_wr_data = '0;

   // predictor state
   logic [bba_pkg::MAX_BLOCKS_DEF-1:0] used_map;
   logic [bba_pkg::COUNT_W-1:0]        block_count;
   alloc_result_type                   expected_results[$];

   int unsigned sent_count    = 0;
   int unsigned checked_count = 0;
   int unsigned fail_count    = 0;
   int unsigned idle_cycles   = 0;
   int unsigned burst_left    = 0;
   int unsigned gap_max       = 0;
   int unsigned stall_mode    = 0;
   int unsigned stall_tick    = 0;
   int unsigned cur_limit     = bba_pkg::MAX_BLOCKS_DEF;

   bitmap_block_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic alloc_result_type predict_result(
      input logic cmd, input logic [bba_pkg::BLOCK_W-1:0] blk);
      alloc_result_type res;
      int unsigned      lim;
      lim = (block_count > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF : block_count;
      res.grant = '0;
      if (cmd == bba_pkg::CMD_ALLOC) begin
         res.status = bba_pkg::STAT_FULL;
         for (int i = 0; i < lim; i++) begin
            if (!used_map[i]) begin
               used_map[i] = 1'b1;
               res.grant   = bba_pkg::BLOCK_W'(i);
               res.status  = bba_pkg::STAT_OK;
               break;
            end
         end
      end else if (blk >= lim) begin
         res.status = bba_pkg::STAT_RANGE;
      end else begin
         used_map[blk] = 1'b0;
         res.grant     = blk;
         res.status    = bba_pkg::STAT_OK;
      end
      return res;
   endfunction

   // track config and requests, check each result against the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         used_map    = '0;
         block_count = bba_pkg::COUNT_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            block_count = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_result(req_tuser, req_tdata[11:0]));
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[11:0] !== want.grant) begin
                  $error("granted_block: expected %0d, actual %0d", want.grant,
                         rsp_tdata[11:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[15:12] !== 4'b0000) begin
                  $error("pad: expected 0, actual %0d", rsp_tdata[15:12]);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL bitmap_block_allocator");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((stall_tick % 7) < 4);
         default: rsp_tready <= ((stall_tick % 64) < 40);
      endcase
   end

   task automatic send_cmd(input logic cmd, input logic [bba_pkg::BLOCK_W-1:0] blk);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, blk};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // hold requests until every outstanding transaction has its result
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (checked_count < sent_count) @(posedge clock);
   endtask

   task automatic set_block_count(input int unsigned value);
      wait_for_results();
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bba_pkg::COUNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = (bba_pkg::COUNT_W'(value) > bba_pkg::MAX_BLOCKS_DEF) ?
                  bba_pkg::MAX_BLOCKS_DEF : bba_pkg::COUNT_W'(value);
   endtask

   task automatic test_first_fit();
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'hFFF);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'd1);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'd4095);
      // free of a block that is already free
      send_cmd(bba_pkg::CMD_FREE, 12'd4095);
      send_cmd(bba_pkg::CMD_FREE, 12'd0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'h555);
   endtask

   task automatic test_count_limits();
      set_block_count(1);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'd1);
      send_cmd(bba_pkg::CMD_FREE, 12'd0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      // no usable block at all
      set_block_count(0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'd0);
      // saturates to the full map
      set_block_count(8191);
      send_cmd(bba_pkg::CMD_FREE, 12'd4095);
      send_cmd(bba_pkg::CMD_ALLOC, 12'hFFF);
   endtask

   task automatic test_shrink_grow();
      set_block_count(2);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'd2);
      // used bits above the old count count again
      set_block_count(4097);
      send_cmd(bba_pkg::CMD_ALLOC, 12'd0);
      send_cmd(bba_pkg::CMD_FREE, 12'hAAA);
   endtask

   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned phase_items;
      int unsigned pick;
      int unsigned hi;
      int unsigned count_value;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0: count_value = 0;
            1: count_value = bba_pkg::MAX_BLOCKS_DEF;
            2: count_value = $urandom_range(bba_pkg::MAX_BLOCKS_DEF + 1, 8191);
            3: count_value = 8191;
            4, 5: count_value = $urandom_range(65, bba_pkg::MAX_BLOCKS_DEF - 1);
            default: count_value = $urandom_range(1, 64);
         endcase
         set_block_count(count_value);
         stall_mode = $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 2;
            2: gap_max = 6;
            default: gap_max = 15;
         endcase
         phase_items = $urandom_range(20, 80);
         repeat (phase_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               send_cmd(bba_pkg::CMD_ALLOC, bba_pkg::BLOCK_W'($urandom_range(0, 4095)));
            end else if (pick < 88 && cur_limit > 0) begin
               // mostly low blocks, where the allocations land
               hi = (pick < 72 || cur_limit < 64) ? cur_limit : 64;
               send_cmd(bba_pkg::CMD_FREE, bba_pkg::BLOCK_W'($urandom_range(0, hi - 1)));
            end else begin
               send_cmd(bba_pkg::CMD_FREE, bba_pkg::BLOCK_W'($urandom_range(0, 4095)));
            end
            sent++;
            if ($urandom_range(0, 63) == 0)
               wait_for_results();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_fit();
      test_count_limits();
      test_shrink_grow();
      test_random_traffic();
      wait_for_results();
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("results missing: %0d expected transactions left",
                expected_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("PASS bitmap_block_allocator");
      else
         $display("FAIL bitmap_block_allocator");
      $finish;
   end

endmodule

`default_nettype wire
